>>> hw/rtl/fplru_pkg.sv
// Shared widths and handshake structs for the frame phase lock rate update block.
package fplru_pkg;

    // shift-subtract divider: dividend, divisor and step counter widths
    localparam int NUM_W = 66;
    localparam int DEN_W = 42;
    localparam int CNT_W = 7;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> hw/rtl/fplru_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, left-aligned dividend.
module fplru_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fplru_pkg::div_req_t                 req,
    input  logic [fplru_pkg::NUM_W-1:0]         dividend,
    input  logic [fplru_pkg::DEN_W-1:0]         divisor,
    output fplru_pkg::div_stat_t                stat,
    output logic [fplru_pkg::NUM_W-1:0]         quotient,
    output logic [fplru_pkg::DEN_W-1:0]         remainder
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [fplru_pkg::CNT_W-1:0]   cnt_reg;
    logic [fplru_pkg::NUM_W-1:0]   num_reg;
    logic [fplru_pkg::DEN_W-1:0]   rem_reg;
    logic [fplru_pkg::DEN_W-1:0]   den_reg;

    logic [fplru_pkg::DEN_W:0]     rem_sh;
    logic [fplru_pkg::DEN_W:0]     rem_dif;
    logic                          fits;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[fplru_pkg::NUM_W-1]};
        fits    = (rem_sh >= {1'b0, den_reg});
        rem_dif = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= req.count;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == fplru_pkg::CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[fplru_pkg::NUM_W-2:0], fits};
            rem_reg <= fits ? rem_dif[fplru_pkg::DEN_W-1:0] : rem_sh[fplru_pkg::DEN_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = num_reg;
    assign remainder = rem_reg;

endmodule

>>> hw/rtl/frame_phase_lock_rate_update.sv
// Top level: phase error and proportional rate correction per frame timestamp.
//
// One timestamp word is taken at a time. With the loop enabled a word passes from acceptance
// to the result word through six passes of the shared shift-subtract divider (one quotient
// bit per cycle, 64+40+33+42+58+66 steps) plus a bit-serial multiply of the base rate; the
// multiply and the last division are skipped when the corrected rate clamps at zero. With
// the loop disabled the word goes straight to the output register without the divider.
// The next timestamp is taken as soon as the result sits in the output register,
// even if the consumer has not taken it yet. Configuration lives on a 64-bit APB
// port, register i at byte address 8*i; write only while no word is in flight.
module frame_phase_lock_rate_update (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    // timestamp channel
    input  logic               frame_valid,
    output logic               frame_ready,
    input  logic [63:0]        timestamp_us,
    // result channel
    output logic               rate_valid,
    input  logic               rate_ready,
    output logic [15:0]        rate_q8,
    output logic               rate_changed,
    output logic               in_pulse,
    output logic signed [40:0] phase_error_us,
    output logic signed [17:0] phase_error_frac
);

    localparam logic [2:0] REG_LOOP_ENABLE = 3'd0;
    localparam logic [2:0] REG_PWM_PERIOD  = 3'd1;
    localparam logic [2:0] REG_DIVIDER     = 3'd2;
    localparam logic [2:0] REG_START_TIME  = 3'd3;
    localparam logic [2:0] REG_START_UNC   = 3'd4;
    localparam logic [2:0] REG_OFFSET      = 3'd5;
    localparam logic [2:0] REG_PULSE_HIGH  = 3'd6;
    localparam logic [2:0] REG_BASE_RATE   = 3'd7;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_D1S  = 5'd1;
    localparam logic [4:0] ST_D1W  = 5'd2;
    localparam logic [4:0] ST_D2S  = 5'd3;
    localparam logic [4:0] ST_D2W  = 5'd4;
    localparam logic [4:0] ST_D3S  = 5'd5;
    localparam logic [4:0] ST_D3W  = 5'd6;
    localparam logic [4:0] ST_NM   = 5'd7;
    localparam logic [4:0] ST_NW   = 5'd8;
    localparam logic [4:0] ST_D4S  = 5'd9;
    localparam logic [4:0] ST_D4W  = 5'd10;
    localparam logic [4:0] ST_D5S  = 5'd11;
    localparam logic [4:0] ST_D5W  = 5'd12;
    localparam logic [4:0] ST_YM   = 5'd13;
    localparam logic [4:0] ST_YA   = 5'd14;
    localparam logic [4:0] ST_YC   = 5'd15;
    localparam logic [4:0] ST_MUL  = 5'd16;
    localparam logic [4:0] ST_D6S  = 5'd17;
    localparam logic [4:0] ST_D6W  = 5'd18;
    localparam logic [4:0] ST_FIN  = 5'd19;

    localparam logic [fplru_pkg::CNT_W-1:0] STEPS_DT   = 7'd64;
    localparam logic [fplru_pkg::CNT_W-1:0] STEPS_MOD  = 7'd40;
    localparam logic [fplru_pkg::CNT_W-1:0] STEPS_ELAP = 7'd33;
    localparam logic [fplru_pkg::CNT_W-1:0] STEPS_PERR = 7'd42;
    localparam logic [fplru_pkg::CNT_W-1:0] STEPS_FRAC = 7'd58;
    localparam logic [fplru_pkg::CNT_W-1:0] STEPS_RATE = 7'd66;

    localparam logic signed [17:0] FRAC_MAX = 18'sh1FFFF;
    localparam logic signed [17:0] FRAC_MIN = 18'sh20000;
    localparam logic [15:0]        RATE_MAX = 16'hFFFF;

    // configuration registers
    logic               loop_enable_reg;
    logic [31:0]        pwm_period_reg;
    logic [7:0]         divider_reg;
    logic [63:0]        start_time_reg;
    logic [9:0]         start_unc_reg;
    logic signed [31:0] phase_offset_reg;
    logic [31:0]        pulse_high_reg;
    logic [15:0]        base_rate_reg;

    // control
    logic [4:0]         state_reg;
    logic [4:0]         state_next;
    logic               rate_valid_reg;
    logic [15:0]        last_rate_reg;
    logic               last_valid_reg;

    // work registers
    logic [63:0]        ts_reg;
    logic               early_reg;
    logic               upd_reg;
    logic signed [34:0] err_reg;
    logic signed [42:0] nerr_reg;
    logic signed [50:0] y_reg;
    logic [65:0]        acc_reg;
    logic [3:0]         mcnt_reg;
    logic [15:0]        res_rate_reg;
    logic               res_pulse_reg;
    logic signed [40:0] res_perr_reg;
    logic signed [17:0] res_frac_reg;

    // output register
    logic [15:0]        rate_q8_reg;
    logic               rate_changed_reg;
    logic               in_pulse_reg;
    logic signed [40:0] phase_error_us_reg;
    logic signed [17:0] phase_error_frac_reg;

    logic                          cfg_write;
    logic                          accept;
    logic                          fin_load;
    logic [31:0]                   p_eff;
    logic [7:0]                    d_eff;
    logic [41:0]                   p_k;
    logic [15:0]                   ref_rate;
    logic                          early;
    logic [63:0]                   dt;
    logic [39:0]                   md;
    logic [32:0]                   elap_num;
    logic signed [43:0]            nprod;
    logic                          nneg;
    logic [42:0]                   nabs;
    logic signed [50:0]            nx;

    fplru_pkg::div_req_t           div_req;
    fplru_pkg::div_stat_t          div_stat;
    logic [fplru_pkg::NUM_W-1:0]   div_num;
    logic [fplru_pkg::DEN_W-1:0]   div_den;
    logic [fplru_pkg::NUM_W-1:0]   div_quo;
    logic [fplru_pkg::DEN_W-1:0]   div_rem;

    fplru_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_num),
        .divisor   (div_den),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[5:3])
            REG_LOOP_ENABLE: prdata = {63'd0, loop_enable_reg};
            REG_PWM_PERIOD:  prdata = {32'd0, pwm_period_reg};
            REG_DIVIDER:     prdata = {56'd0, divider_reg};
            REG_START_TIME:  prdata = start_time_reg;
            REG_START_UNC:   prdata = {54'd0, start_unc_reg};
            REG_OFFSET:      prdata = {32'd0, phase_offset_reg};
            REG_PULSE_HIGH:  prdata = {32'd0, pulse_high_reg};
            REG_BASE_RATE:   prdata = {48'd0, base_rate_reg};
            default:         prdata = '0;
        endcase
    end

    // a zero period or divider counts as one
    assign p_eff = (pwm_period_reg == 32'd0) ? 32'd1 : pwm_period_reg;
    assign d_eff = (divider_reg == 8'd0) ? 8'd1 : divider_reg;
    // 1000 * p as 1024p - 16p - 8p
    assign p_k   = {p_eff, 10'd0} - {6'd0, p_eff, 4'd0} - {7'd0, p_eff, 3'd0};

    assign ref_rate    = last_valid_reg ? last_rate_reg : base_rate_reg;
    assign frame_ready = (state_reg == ST_IDLE);
    assign accept      = frame_valid && frame_ready;
    assign fin_load    = (state_reg == ST_FIN) && (!rate_valid_reg || rate_ready);

    assign early    = (ts_reg < start_time_reg);
    assign dt       = early ? 64'd0 : (ts_reg - start_time_reg);
    assign md       = 40'(div_rem[31:0]) * 40'(d_eff);
    assign elap_num = 33'(div_rem[31:0]) + 33'(d_eff) - 33'd1;
    assign nprod    = 44'(err_reg) * 44'($signed({1'b0, d_eff}));
    assign nneg     = nerr_reg[42];
    assign nabs     = nneg ? (43'd0 - nerr_reg) : nerr_reg;
    assign nx       = 51'(nerr_reg);

    always_comb
    begin
        div_req = '0;
        div_num = '0;
        div_den = '0;
        case (state_reg)
            ST_D1S:
            begin
                div_req.start = 1'b1;
                div_req.count = STEPS_DT;
                div_num       = {dt, 2'd0};
                div_den       = 42'(p_eff);
            end
            ST_D2S:
            begin
                div_req.start = 1'b1;
                div_req.count = STEPS_MOD;
                div_num       = {md, 26'd0};
                div_den       = 42'(p_eff);
            end
            ST_D3S:
            begin
                div_req.start = 1'b1;
                div_req.count = STEPS_ELAP;
                div_num       = {elap_num, 33'd0};
                div_den       = 42'(d_eff);
            end
            ST_D4S:
            begin
                div_req.start = 1'b1;
                div_req.count = STEPS_PERR;
                div_num       = {nabs[41:0], 24'd0};
                div_den       = 42'(d_eff);
            end
            ST_D5S:
            begin
                // same left-aligned word: 58 steps yield |n| * 65536 / p
                div_req.start = 1'b1;
                div_req.count = STEPS_FRAC;
                div_num       = {nabs[41:0], 24'd0};
                div_den       = 42'(p_eff);
            end
            ST_D6S:
            begin
                div_req.start = 1'b1;
                div_req.count = STEPS_RATE;
                div_num       = acc_reg;
                div_den       = p_k;
            end
            default:
            begin
                div_req = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = loop_enable_reg ? ST_D1S : ST_FIN;
            ST_D1S:  state_next = ST_D1W;
            ST_D1W:  if (div_stat.done) state_next = ST_D2S;
            ST_D2S:  state_next = ST_D2W;
            ST_D2W:  if (div_stat.done) state_next = ST_D3S;
            ST_D3S:  state_next = ST_D3W;
            ST_D3W:  if (div_stat.done) state_next = ST_NM;
            ST_NM:   state_next = ST_NW;
            ST_NW:   state_next = ST_D4S;
            ST_D4S:  state_next = ST_D4W;
            ST_D4W:  if (div_stat.done) state_next = ST_D5S;
            ST_D5S:  state_next = ST_D5W;
            ST_D5W:  if (div_stat.done) state_next = ST_YM;
            ST_YM:   state_next = ST_YA;
            ST_YA:   state_next = ST_YC;
            ST_YC:   state_next = y_reg[50] ? ST_FIN : ST_MUL;
            ST_MUL:  if (mcnt_reg == 4'd0) state_next = ST_D6S;
            ST_D6S:  state_next = ST_D6W;
            ST_D6W:  if (div_stat.done) state_next = ST_FIN;
            ST_FIN:  if (fin_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_enable_reg  <= 1'b0;
            pwm_period_reg   <= 32'd33333;
            divider_reg      <= 8'd1;
            start_time_reg   <= 64'd0;
            start_unc_reg    <= 10'd0;
            phase_offset_reg <= 32'sd0;
            pulse_high_reg   <= 32'd0;
            base_rate_reg    <= 16'd7680;
            state_reg        <= ST_IDLE;
            rate_valid_reg   <= 1'b0;
            last_rate_reg    <= 16'd0;
            last_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (paddr[5:3])
                    REG_LOOP_ENABLE: loop_enable_reg  <= pwdata[0];
                    REG_PWM_PERIOD:  pwm_period_reg   <= pwdata[31:0];
                    REG_DIVIDER:     divider_reg      <= pwdata[7:0];
                    REG_START_TIME:  start_time_reg   <= pwdata;
                    REG_START_UNC:   start_unc_reg    <= pwdata[9:0];
                    REG_OFFSET:      phase_offset_reg <= pwdata[31:0];
                    REG_PULSE_HIGH:  pulse_high_reg   <= pwdata[31:0];
                    REG_BASE_RATE:   base_rate_reg    <= pwdata[15:0];
                    default:         loop_enable_reg  <= loop_enable_reg;
                endcase
            end
            if (fin_load)
            begin
                rate_valid_reg <= 1'b1;
                if (upd_reg)
                begin
                    last_rate_reg  <= res_rate_reg;
                    last_valid_reg <= 1'b1;
                end
            end
            else if (rate_ready)
            begin
                rate_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ts_reg  <= timestamp_us;
                    upd_reg <= loop_enable_reg;
                    // loop off: report the held rate, nothing else
                    res_rate_reg  <= ref_rate;
                    res_pulse_reg <= 1'b0;
                    res_perr_reg  <= '0;
                    res_frac_reg  <= '0;
                end
            end
            ST_D1S:
            begin
                early_reg <= early;
            end
            ST_D1W:
            begin
                if (div_stat.done)
                    res_pulse_reg <= !early_reg && (div_rem[31:0] <= pulse_high_reg);
            end
            ST_D3W:
            begin
                if (div_stat.done)
                    err_reg <= $signed({2'b00, div_quo[32:0]}) + 35'(phase_offset_reg)
                               + $signed({26'd0, start_unc_reg[9:1]});
            end
            ST_NM:
            begin
                nerr_reg <= nprod[42:0];
            end
            ST_NW:
            begin
                // wrap once into the lower half period
                if (!nerr_reg[42] && ({nerr_reg[41:0], 1'b0} > 43'(p_eff)))
                    nerr_reg <= nerr_reg - $signed({11'd0, p_eff});
            end
            ST_D4W:
            begin
                if (div_stat.done)
                    res_perr_reg <= nneg ? (41'd0 - div_quo[40:0]) : div_quo[40:0];
            end
            ST_D5W:
            begin
                if (div_stat.done)
                begin
                    if (!nneg)
                        res_frac_reg <= (|div_quo[65:17]) ? FRAC_MAX
                                                          : {1'b0, div_quo[16:0]};
                    else if ((|div_quo[65:18]) || (div_quo[17] && (|div_quo[16:0])))
                        res_frac_reg <= FRAC_MIN;
                    else
                        res_frac_reg <= 18'd0 - div_quo[17:0];
                end
            end
            ST_YM:
            begin
                // 233 * n as 256n - 16n - 8n + n
                y_reg <= (nx <<< 8) - (nx <<< 4) - (nx <<< 3) + nx;
            end
            ST_YA:
            begin
                y_reg <= y_reg + $signed({9'd0, p_k});
            end
            ST_YC:
            begin
                res_rate_reg <= 16'd0;
                acc_reg      <= '0;
                mcnt_reg     <= 4'd15;
            end
            ST_MUL:
            begin
                // base * y, one base bit per cycle, MSB first
                acc_reg  <= {acc_reg[64:0], 1'b0}
                            + (base_rate_reg[mcnt_reg] ? {16'd0, y_reg[49:0]} : 66'd0);
                mcnt_reg <= mcnt_reg - 4'd1;
            end
            ST_D6W:
            begin
                if (div_stat.done)
                    res_rate_reg <= (|div_quo[65:16]) ? RATE_MAX : div_quo[15:0];
            end
            default:
            begin
                ts_reg <= ts_reg;
            end
        endcase

        if (fin_load)
        begin
            rate_q8_reg          <= res_rate_reg;
            rate_changed_reg     <= upd_reg && (res_rate_reg != ref_rate);
            in_pulse_reg         <= res_pulse_reg;
            phase_error_us_reg   <= res_perr_reg;
            phase_error_frac_reg <= res_frac_reg;
        end
    end

    assign rate_valid       = rate_valid_reg;
    assign rate_q8          = rate_q8_reg;
    assign rate_changed     = rate_changed_reg;
    assign in_pulse         = in_pulse_reg;
    assign phase_error_us   = phase_error_us_reg;
    assign phase_error_frac = phase_error_frac_reg;

    // divider is never restarted mid-division
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // a finished division is only seen where the sequencer waits for it
    a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_D1W || state_reg == ST_D2W
                           || state_reg == ST_D3W || state_reg == ST_D4W
                           || state_reg == ST_D5W || state_reg == ST_D6W))
        else $error("divider done outside a wait state");

    // the held rate follows every word produced with the loop running
    a_last_rate_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_load && upd_reg) |=> (last_valid_reg && last_rate_reg == rate_q8_reg))
        else $error("last rate does not match delivered rate");

endmodule
